// ----- src/sprwt_pkg.sv -----
// Package for the receive window tracker: sequencer states, result kinds
// and configuration register indexes. No dependencies.
package sprwt_pkg;

    localparam int SEQ_W  = 16;
    localparam int HOST_W = 48;
    localparam int KIND_W = 3;
    localparam int CFG_AW = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_DELIVER = 3'd0,
        KIND_ACK     = 3'd1,
        KIND_OUTWIN  = 3'd2,
        KIND_DUP     = 3'd3,
        KIND_PEER    = 3'd4
    } kind_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_PEER_HOST    = 2'd0,
        CFG_PEER_SOCKET  = 2'd1,
        CFG_PEER_CONN_ID = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DELIVER,
        ST_SEND,
        ST_ACK
    } state_t;

endpackage

// ----- src/spp_receive_window_tracker.sv -----
// Receive window tracker for a sequenced packet connection: peer check,
// reorder window, in-order delivery and acknowledgement. Uses sprwt_pkg.
//
//   channel   dir  handshake        contents
//   s_*       in   s_valid/s_ready  received packet header, one per beat
//   m_*       out  m_valid/m_ready  deliver, ack or drop result, one per beat
//   cfg_*     in   cfg_wr_en        peer host, socket and connection id
//
// A header is taken in ST_IDLE and checked in ST_CHECK, which sends a drop or
// mismatch; ST_DELIVER then hands out in-order data, and a kept packet passes
// ST_SEND and goes to ST_ACK when an ack goes out. A single shared 16-bit adder
// serves the window offset, the receive and send sequence increments and the ack
// allocation. Reset is synchronous; it empties the window and zeroes both
// sequences. A stalled result beat holds the sequencer until it is taken.
module spp_receive_window_tracker
    import sprwt_pkg::*;
#(
    parameter int WINDOW = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_AW-1:0]    cfg_addr,
    input  logic [HOST_W-1:0]    cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [HOST_W-1:0]    s_src_host,
    input  logic [SEQ_W-1:0]     s_src_socket,
    input  logic [SEQ_W-1:0]     s_src_conn_id,
    input  logic                 s_is_data,
    input  logic                 s_wants_ack,
    input  logic [SEQ_W-1:0]     s_seq_num,
    input  logic [SEQ_W-1:0]     s_alloc_num,
    input  logic [SEQ_W-1:0]     s_payload_tag,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [KIND_W-1:0]    m_kind,
    output logic [SEQ_W-1:0]     m_out_tag,
    output logic [SEQ_W-1:0]     m_ack_send_seq,
    output logic [SEQ_W-1:0]     m_ack_recv_seq,
    output logic [SEQ_W-1:0]     m_ack_alloc,
    output logic                 m_last
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    state_t              state_reg, state_next;

    logic [HOST_W-1:0]   peer_host_reg;
    logic [SEQ_W-1:0]    peer_socket_reg;
    logic [SEQ_W-1:0]    peer_conn_id_reg;

    logic [HOST_W-1:0]   host_reg, host_next;
    logic [SEQ_W-1:0]    socket_reg, socket_next;
    logic [SEQ_W-1:0]    conn_reg, conn_next;
    logic                is_data_reg, is_data_next;
    logic                need_ack_reg, need_ack_next;
    logic [SEQ_W-1:0]    seq_reg, seq_next;
    logic [SEQ_W-1:0]    alloc_reg, alloc_next;
    logic [SEQ_W-1:0]    tag_reg, tag_next;

    logic [SEQ_W-1:0]    recv_seq_reg, recv_seq_next;
    logic [SEQ_W-1:0]    send_seq_reg, send_seq_next;
    logic [WINDOW-1:0]   filled_reg, filled_next;
    logic [SEQ_W-1:0]    slot_tag_reg  [WINDOW];
    logic [SEQ_W-1:0]    slot_tag_next [WINDOW];

    logic                m_valid_reg, m_valid_next;
    kind_t               m_kind_reg, m_kind_next;
    logic [SEQ_W-1:0]    m_out_tag_reg, m_out_tag_next;
    logic [SEQ_W-1:0]    m_send_reg, m_send_next;
    logic [SEQ_W-1:0]    m_recv_reg, m_recv_next;
    logic [SEQ_W-1:0]    m_alloc_reg, m_alloc_next;
    logic                m_last_reg, m_last_next;

    logic [SEQ_W-1:0]    add_a;
    logic [SEQ_W-1:0]    add_b;
    logic                add_cin;
    logic [SEQ_W-1:0]    add_sum;
    logic [SEQ_W-1:0]    free_cnt;
    logic [IDX_W-1:0]    off_idx;
    logic                out_free;
    logic                peer_ok;

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_out_tag      = m_out_tag_reg;
    assign m_ack_send_seq = m_send_reg;
    assign m_ack_recv_seq = m_recv_reg;
    assign m_ack_alloc    = m_alloc_reg;
    assign m_last         = m_last_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign peer_ok  = (host_reg == peer_host_reg) && (socket_reg == peer_socket_reg)
                      && (conn_reg == peer_conn_id_reg);
    assign free_cnt = SEQ_W'($countones(~filled_reg));
    assign off_idx  = add_sum[IDX_W-1:0];

    // shared adder
    always_comb begin
        unique case (state_reg)
            ST_CHECK: begin
                add_a   = seq_reg;
                add_b   = ~recv_seq_reg;
                add_cin = 1'b1;
            end
            ST_DELIVER: begin
                add_a   = recv_seq_reg;
                add_b   = '0;
                add_cin = 1'b1;
            end
            ST_SEND: begin
                add_a   = send_seq_reg;
                add_b   = '0;
                add_cin = 1'b1;
            end
            ST_ACK: begin
                add_a   = recv_seq_reg;
                add_b   = free_cnt;
                add_cin = 1'b0;
            end
            default: begin
                add_a   = '0;
                add_b   = '0;
                add_cin = 1'b0;
            end
        endcase
        add_sum = add_a + add_b + SEQ_W'(add_cin);
    end

    always_comb begin
        state_next     = state_reg;
        host_next      = host_reg;
        socket_next    = socket_reg;
        conn_next      = conn_reg;
        is_data_next   = is_data_reg;
        need_ack_next  = need_ack_reg;
        seq_next       = seq_reg;
        alloc_next     = alloc_reg;
        tag_next       = tag_reg;
        recv_seq_next  = recv_seq_reg;
        send_seq_next  = send_seq_reg;
        filled_next    = filled_reg;
        slot_tag_next  = slot_tag_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_kind_next    = m_kind_reg;
        m_out_tag_next = m_out_tag_reg;
        m_send_next    = m_send_reg;
        m_recv_next    = m_recv_reg;
        m_alloc_next   = m_alloc_reg;
        m_last_next    = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    host_next     = s_src_host;
                    socket_next   = s_src_socket;
                    conn_next     = s_src_conn_id;
                    is_data_next  = s_is_data;
                    need_ack_next = s_wants_ack;
                    seq_next      = s_seq_num;
                    alloc_next    = s_alloc_num;
                    tag_next      = s_payload_tag;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!peer_ok || (is_data_reg && (add_sum >= SEQ_W'(WINDOW)))
                        || (is_data_reg && filled_reg[off_idx])) begin
                    if (out_free) begin
                        m_valid_next   = 1'b1;
                        m_out_tag_next = '0;
                        m_send_next    = '0;
                        m_recv_next    = '0;
                        m_alloc_next   = '0;
                        m_last_next    = 1'b1;
                        if (!peer_ok) begin
                            m_kind_next = KIND_PEER;
                        end else if (add_sum >= SEQ_W'(WINDOW)) begin
                            m_kind_next = KIND_OUTWIN;
                        end else begin
                            m_kind_next = KIND_DUP;
                        end
                        state_next = ST_IDLE;
                    end
                end else if (is_data_reg) begin
                    filled_next[off_idx]   = 1'b1;
                    slot_tag_next[off_idx] = tag_reg;
                    state_next             = ST_DELIVER;
                end else begin
                    state_next = ST_SEND;
                end
            end
            ST_DELIVER: begin
                if (filled_reg[0]) begin
                    if (out_free) begin
                        m_valid_next   = 1'b1;
                        m_kind_next    = KIND_DELIVER;
                        m_out_tag_next = slot_tag_reg[0];
                        m_send_next    = '0;
                        m_recv_next    = '0;
                        m_alloc_next   = '0;
                        m_last_next    = 1'b0;
                        // advance the window by one slot
                        filled_next    = filled_reg >> 1;
                        for (int i = 0; i < WINDOW - 1; i++) begin
                            slot_tag_next[i] = slot_tag_reg[i+1];
                        end
                        recv_seq_next  = add_sum;
                        need_ack_next  = 1'b1;
                    end
                end else begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                if (alloc_reg == add_sum) begin
                    send_seq_next = add_sum;
                    state_next    = ST_ACK;
                end else if (need_ack_reg) begin
                    state_next = ST_ACK;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_ACK: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_kind_next    = KIND_ACK;
                    m_out_tag_next = '0;
                    m_send_next    = send_seq_reg;
                    m_recv_next    = recv_seq_reg;
                    m_alloc_next   = add_sum;
                    m_last_next    = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            recv_seq_reg     <= '0;
            send_seq_reg     <= '0;
            filled_reg       <= '0;
            m_valid_reg      <= 1'b0;
            peer_host_reg    <= '0;
            peer_socket_reg  <= '0;
            peer_conn_id_reg <= '0;
        end else begin
            state_reg    <= state_next;
            recv_seq_reg <= recv_seq_next;
            send_seq_reg <= send_seq_next;
            filled_reg   <= filled_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_PEER_HOST:    peer_host_reg    <= cfg_wdata;
                    CFG_PEER_SOCKET:  peer_socket_reg  <= cfg_wdata[SEQ_W-1:0];
                    CFG_PEER_CONN_ID: peer_conn_id_reg <= cfg_wdata[SEQ_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        host_reg      <= host_next;
        socket_reg    <= socket_next;
        conn_reg      <= conn_next;
        is_data_reg   <= is_data_next;
        need_ack_reg  <= need_ack_next;
        seq_reg       <= seq_next;
        alloc_reg     <= alloc_next;
        tag_reg       <= tag_next;
        slot_tag_reg  <= slot_tag_next;
        m_kind_reg    <= m_kind_next;
        m_out_tag_reg <= m_out_tag_next;
        m_send_reg    <= m_send_next;
        m_recv_reg    <= m_recv_next;
        m_alloc_reg   <= m_alloc_next;
        m_last_reg    <= m_last_next;
    end

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for spp_receive_window_tracker: peer check, reorder window,
// in-order delivery and acks, all checked against an in-bench window tracker.
// Depends on sprwt_pkg and the block's RTL only.
module testbench;
    import sprwt_pkg::*;

    localparam int WIN = 4;

    typedef struct packed {
        logic [HOST_W-1:0] host;
        logic [SEQ_W-1:0]  sock;
        logic [SEQ_W-1:0]  conn;
        logic              is_data;
        logic              wants_ack;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  alloc;
        logic [SEQ_W-1:0]  tag;
    } hdr_t;

    typedef struct packed {
        kind_t            kind;
        logic [SEQ_W-1:0] tag;
        logic [SEQ_W-1:0] snd;
        logic [SEQ_W-1:0] rcv;
        logic [SEQ_W-1:0] alloc;
        logic             last;
    } rslt_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [HOST_W-1:0] cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    hdr_t              hdr_out = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [KIND_W-1:0] m_kind;
    logic [SEQ_W-1:0]  m_out_tag;
    logic [SEQ_W-1:0]  m_ack_send_seq;
    logic [SEQ_W-1:0]  m_ack_recv_seq;
    logic [SEQ_W-1:0]  m_ack_alloc;
    logic              m_last;

    // window tracker state and peer settings
    logic [HOST_W-1:0] want_host = '0;
    logic [SEQ_W-1:0]  want_sock = '0;
    logic [SEQ_W-1:0]  want_conn = '0;
    logic [SEQ_W-1:0]  rx_seq = '0;
    logic [SEQ_W-1:0]  tx_seq = '0;
    logic              slot_full [WIN];
    logic [SEQ_W-1:0]  slot_tag [WIN];

    hdr_t  hdr_backlog [$];
    rslt_t due_results [$];
    rslt_t head_result;
    bit    calm = 1'b0;
    int    errors = 0;
    int    hdrs_taken = 0;
    int    n_results = 0;
    int    n_deliver = 0;
    int    n_ack = 0;
    int    n_drop = 0;

    always #6 aclk = ~aclk;

    spp_receive_window_tracker #(
        .WINDOW(WIN)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_src_host     (hdr_out.host),
        .s_src_socket   (hdr_out.sock),
        .s_src_conn_id  (hdr_out.conn),
        .s_is_data      (hdr_out.is_data),
        .s_wants_ack    (hdr_out.wants_ack),
        .s_seq_num      (hdr_out.seq),
        .s_alloc_num    (hdr_out.alloc),
        .s_payload_tag  (hdr_out.tag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_out_tag      (m_out_tag),
        .m_ack_send_seq (m_ack_send_seq),
        .m_ack_recv_seq (m_ack_recv_seq),
        .m_ack_alloc    (m_ack_alloc),
        .m_last         (m_last)
    );

    initial begin
        for (int i = 0; i < WIN; i++) begin
            slot_full[i] = 1'b0;
            slot_tag[i] = '0;
        end
    end

    function automatic rslt_t result_of(kind_t kind, logic [SEQ_W-1:0] tag,
                                        logic [SEQ_W-1:0] snd, logic [SEQ_W-1:0] rcv,
                                        logic [SEQ_W-1:0] alloc);
        rslt_t r;
        r.kind = kind;
        r.tag = tag;
        r.snd = snd;
        r.rcv = rcv;
        r.alloc = alloc;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic void advance_window(hdr_t h);
        rslt_t            step_out [$];
        logic [SEQ_W-1:0] off;
        logic [SEQ_W-1:0] next_tx;
        int               run;
        int               nfree;
        bit               ack_due;
        ack_due = h.wants_ack;
        run = 0;
        nfree = 0;
        if (h.host != want_host || h.sock != want_sock || h.conn != want_conn) begin
            step_out.push_back(result_of(KIND_PEER, '0, '0, '0, '0));
        end else begin
            off = h.seq - rx_seq;
            if (h.is_data && off >= WIN) begin
                step_out.push_back(result_of(KIND_OUTWIN, '0, '0, '0, '0));
            end else if (h.is_data && slot_full[off]) begin
                step_out.push_back(result_of(KIND_DUP, '0, '0, '0, '0));
            end else begin
                if (h.is_data) begin
                    slot_full[off] = 1'b1;
                    slot_tag[off] = h.tag;
                    while (run < WIN && slot_full[run]) begin
                        step_out.push_back(result_of(KIND_DELIVER, slot_tag[run], '0, '0, '0));
                        run++;
                    end
                    if (run > 0) begin
                        for (int i = 0; i < WIN; i++) begin
                            if (i + run < WIN) begin
                                slot_full[i] = slot_full[i + run];
                                slot_tag[i] = slot_tag[i + run];
                            end else begin
                                slot_full[i] = 1'b0;
                            end
                        end
                        rx_seq = rx_seq + SEQ_W'(run);
                        ack_due = 1'b1;
                    end
                end
                next_tx = tx_seq + 16'd1;
                if (h.alloc == next_tx) begin
                    tx_seq = next_tx;
                    ack_due = 1'b1;
                end
                if (ack_due) begin
                    for (int i = 0; i < WIN; i++)
                        if (!slot_full[i])
                            nfree++;
                    step_out.push_back(result_of(KIND_ACK, '0, tx_seq, rx_seq,
                                                 rx_seq + SEQ_W'(nfree)));
                end
            end
        end
        if (step_out.size() != 0)
            step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i])
            due_results.push_back(step_out[i]);
    endfunction

    function automatic void check_field(string name, logic [SEQ_W-1:0] want,
                                        logic [SEQ_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // driver: hold a beat until taken, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_window(hdr_out);
                hdrs_taken++;
            end
            if (!s_valid || s_ready) begin
                if (hdr_backlog.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
                    s_valid <= 1'b1;
                    hdr_out <= hdr_backlog.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (m_kind == KIND_DELIVER)
                    n_deliver++;
                else if (m_kind == KIND_ACK)
                    n_ack++;
                else
                    n_drop++;
                if (due_results.size() == 0) begin
                    $error("result beat kind %0d with nothing expected", m_kind);
                    errors++;
                end else begin
                    head_result = due_results.pop_front();
                    check_field("kind", SEQ_W'(head_result.kind), SEQ_W'(m_kind));
                    check_field("out_tag", head_result.tag, m_out_tag);
                    check_field("ack_send_seq", head_result.snd, m_ack_send_seq);
                    check_field("ack_recv_seq", head_result.rcv, m_ack_recv_seq);
                    check_field("ack_alloc", head_result.alloc, m_ack_alloc);
                    check_field("last", SEQ_W'(head_result.last), SEQ_W'(m_last));
                end
            end
            m_ready <= calm || ($urandom_range(99) >= 11);
        end
    end

    function automatic logic [HOST_W-1:0] rand_host();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic hdr_t mk_pkt(bit data, bit ack, logic [SEQ_W-1:0] seq,
                                    logic [SEQ_W-1:0] alloc, logic [SEQ_W-1:0] tag);
        hdr_t h;
        h.host = want_host;
        h.sock = want_sock;
        h.conn = want_conn;
        h.is_data = data;
        h.wants_ack = ack;
        h.seq = seq;
        h.alloc = alloc;
        h.tag = tag;
        return h;
    endfunction

    function automatic hdr_t scramble_peer(hdr_t h);
        case ($urandom_range(3))
            0: h.host = h.host ^ (HOST_W'(1) << $urandom_range(HOST_W - 1));
            1: h.sock = h.sock ^ (SEQ_W'(1) << $urandom_range(SEQ_W - 1));
            2: h.conn = 16'($urandom);
            default: begin
                h.host = rand_host();
                h.sock = 16'($urandom);
                h.conn = 16'($urandom);
            end
        endcase
        h.is_data = 1'($urandom);
        h.seq = 16'($urandom);
        return h;
    endfunction

    task automatic set_peer(logic [HOST_W-1:0] host, logic [SEQ_W-1:0] sock,
                            logic [SEQ_W-1:0] conn);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_UNUSED;
        cfg_wdata <= rand_host();
        @(posedge aclk);
        cfg_addr <= CFG_PEER_HOST;
        cfg_wdata <= host;
        @(posedge aclk);
        cfg_addr <= CFG_PEER_SOCKET;
        cfg_wdata <= HOST_W'(sock);
        @(posedge aclk);
        cfg_addr <= CFG_PEER_CONN_ID;
        cfg_wdata <= HOST_W'(conn);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        want_host = host;
        want_sock = sock;
        want_conn = conn;
        @(negedge aclk);
    endtask

    // drain: wait for every header and result, then let the block go idle
    task automatic settle();
        int spin;
        spin = 0;
        while ((hdr_backlog.size() != 0 || s_valid || due_results.size() != 0)
               && spin < 20000) begin
            @(negedge aclk);
            spin++;
        end
        if (due_results.size() != 0) begin
            $error("%0d expected results never arrived", due_results.size());
            errors++;
            due_results.delete();
        end
        repeat (16) @(negedge aclk);
    endtask

    // one burst of window traffic, built on the current window state
    task automatic queue_burst(inout int n);
        int               order [WIN];
        int               j;
        int               t;
        int               k;
        int               pick;
        logic [SEQ_W-1:0] snd;
        hdr_t             h;
        while (hdr_backlog.size() != 0 || s_valid)
            @(negedge aclk);
        snd = tx_seq;
        for (int i = 0; i < WIN; i++)
            order[i] = i;
        for (int i = WIN - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        k = $urandom_range(1, WIN);
        for (int i = 0; i < k; i++) begin
            h = mk_pkt(1'b1, 1'($urandom), rx_seq + SEQ_W'(order[i]), 16'($urandom),
                       16'($urandom));
            pick = $urandom_range(99);
            if (pick < 8) begin
                h.seq = rx_seq + SEQ_W'(WIN) + SEQ_W'($urandom_range(65535 - WIN));
            end else if (pick < 12) begin
                h.seq = rx_seq - 16'd1;
            end else if (pick < 22) begin
                h.is_data = 1'b0;
                h.seq = 16'($urandom);
            end else if (pick < 31) begin
                h = scramble_peer(h);
            end
            if ($urandom_range(2) != 0) begin
                snd = snd + 16'd1;
                h.alloc = snd;
            end
            hdr_backlog.push_back(h);
            n++;
        end
    endtask

    initial begin
        hdr_t h;
        int   n;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        set_peer('0, '0, '0);

        hdr_backlog.push_back(mk_pkt(1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
        hdr_backlog.push_back(mk_pkt(1'b0, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF));
        hdr_backlog.push_back(mk_pkt(1'b0, 1'b0, 16'h0000, 16'h0001, 16'h0000));
        hdr_backlog.push_back(mk_pkt(1'b1, 1'b0, 16'h0001, 16'h0000, 16'hFFFF));
        hdr_backlog.push_back(mk_pkt(1'b1, 1'b1, 16'h0001, 16'h0000, 16'h1234));
        hdr_backlog.push_back(mk_pkt(1'b1, 1'b0, 16'h0000, 16'h0002, 16'h0000));
        hdr_backlog.push_back(mk_pkt(1'b1, 1'b1, 16'h0006, 16'hFFFF, 16'h0001));
        hdr_backlog.push_back(mk_pkt(1'b1, 1'b0, 16'h0001, 16'h0003, 16'h0002));
        hdr_backlog.push_back(mk_pkt(1'b1, 1'b1, 16'hFFFF, 16'h0003, 16'hFFFF));
        h = mk_pkt(1'b1, 1'b1, 16'h0002, 16'h0003, 16'h0005);
        h.host = '1;
        hdr_backlog.push_back(h);
        h = mk_pkt(1'b1, 1'b0, 16'h0002, 16'h0003, 16'h0005);
        h.sock = '1;
        hdr_backlog.push_back(h);
        h = mk_pkt(1'b0, 1'b1, 16'h0002, 16'h0003, 16'h0005);
        h.conn = '1;
        hdr_backlog.push_back(h);
        hdr_backlog.push_back(mk_pkt(1'b1, 1'b0, 16'h0005, 16'h0000, 16'h00A5));
        hdr_backlog.push_back(mk_pkt(1'b1, 1'b1, 16'h0004, 16'h0000, 16'h005A));
        hdr_backlog.push_back(mk_pkt(1'b1, 1'b0, 16'h0003, 16'h0000, 16'hFFFE));
        hdr_backlog.push_back(mk_pkt(1'b1, 1'b1, 16'h0002, 16'h0003, 16'h0001));
        hdr_backlog.push_back(mk_pkt(1'b0, 1'b1, 16'h8000, 16'h0004, 16'h7FFF));
        hdr_backlog.push_back(mk_pkt(1'b1, 1'b0, 16'h0006, 16'hFFFF, 16'hFFFF));
        settle();

        set_peer('1, '1, '1);
        n = 0;
        while (n < 145)
            queue_burst(n);
        settle();

        set_peer(rand_host(), 16'($urandom), 16'($urandom));
        calm = 1'b1;
        n = 0;
        while (n < 150)
            queue_burst(n);
        settle();
        calm = 1'b0;

        set_peer(rand_host(), 16'($urandom), 16'($urandom));
        n = 0;
        while (n < 150)
            queue_burst(n);
        settle();

        $display("summary: %0d headers over four peer settings, %0d result beats checked",
                 hdrs_taken, n_results);
        $display("summary: %0d deliveries, %0d acks, %0d drops or mismatches, recv seq %0d",
                 n_deliver, n_ack, n_drop, rx_seq);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule
